// File: design/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the binary frame encoder.
// ----------------------------------------------------------------------------
package bfe_pkg;

	// Largest number of bytes that one request can cause.
	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned CNT_W       = 4;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [7:0] LEN_HIGH    = 8'h00;

	localparam logic FUNC_START   = 1'b0;
	localparam logic FUNC_PAYLOAD = 1'b1;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic  func;
		byte_t msg_class;
		byte_t message_id;
		byte_t payload_length;
		byte_t payload_byte;
	} item_t;

	// Bytes produced by one request, first byte in element 0.
	typedef struct packed {
		logic                             load;
		logic [MAX_RESULTS-1:0][7:0]      bytes;
		logic [CNT_W-1:0]                 count;
		logic                             has_end;
	} load_t;

endpackage

// File: design/bfe_item_if.sv
// ----------------------------------------------------------------------------
// bfe_item_if
// Request channel of the frame encoder: one start or payload request.
// ----------------------------------------------------------------------------
interface bfe_item_if;
	logic                valid;
	logic                ready;
	logic                func;
	bfe_pkg::byte_t      msg_class;
	bfe_pkg::byte_t      message_id;
	bfe_pkg::byte_t      payload_length;
	bfe_pkg::byte_t      payload_byte;

	modport source (
		output valid, func, msg_class, message_id, payload_length, payload_byte,
		input  ready
	);
	modport sink (
		input  valid, func, msg_class, message_id, payload_length, payload_byte,
		output ready
	);
endinterface

// File: design/bfe_result_if.sv
// ----------------------------------------------------------------------------
// bfe_result_if
// Result channel of the frame encoder: one byte of the framed message.
// ----------------------------------------------------------------------------
interface bfe_result_if;
	logic                valid;
	logic                ready;
	bfe_pkg::byte_t      out_byte;
	logic                run_last;
	logic                frame_last;

	modport source (
		output valid, out_byte, run_last, frame_last,
		input  ready
	);
	modport sink (
		input  valid, out_byte, run_last, frame_last,
		output ready
	);
endinterface

// File: design/binary_frame_encoder.sv
// ----------------------------------------------------------------------------
// binary_frame_encoder
// Builds sync-framed command messages with a Fletcher-8 checksum.
// ----------------------------------------------------------------------------
// A start request emits the sync bytes 0xB5 0x62, class, id, the length and a
// zero high length byte, and restarts the two running sums; every payload
// request emits its byte, and the request that carries the last payload byte
// (or a start with zero length) also emits the sums A and B, the second of
// which is flagged as the end of the frame. A payload request outside a frame
// is taken and dropped. All bytes of one request are formed combinationally
// and loaded into an eight-byte output register, which hands out one byte
// per cycle while result.ready holds; a new request is taken in the cycle
// that the last byte of the previous one leaves. A request yields one result
// byte for an ordinary payload byte, so payload streams through at one
// request per cycle while result.ready holds, three for the closing payload
// byte, and six or eight for a start. A dropped payload request loads no
// bytes. The output register is the only limit on rate.
// ----------------------------------------------------------------------------
module binary_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	bfe_item_if.sink    item,
	bfe_result_if.source result
);

	bfe_pkg::item_t                           req;
	bfe_pkg::load_t                           load;
	logic                                     accept;
	logic                                     take;
	logic [bfe_pkg::MAX_RESULTS-1:0][7:0]     buf_s1;
	logic [bfe_pkg::CNT_W-1:0]                cnt_s1;
	logic                                     end_s1;

	assign req.func           = item.func;
	assign req.msg_class      = item.msg_class;
	assign req.message_id     = item.message_id;
	assign req.payload_length = item.payload_length;
	assign req.payload_byte   = item.payload_byte;

	// The output register is free when empty, or when its final byte leaves now.
	assign take       = result.valid && result.ready;
	assign item.ready = (cnt_s1 == '0) ||
	                    ((cnt_s1 == bfe_pkg::CNT_W'(1)) && result.ready);
	assign accept     = item.valid && item.ready;

	bfe_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (req),
		.load   (load)
	);

	// The remaining byte count is control state; the bytes themselves need no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
			end_s1 <= 1'b0;
		end else if (accept && load.load) begin
			cnt_s1 <= load.count;
			end_s1 <= load.has_end;
		end else if (take) begin
			cnt_s1 <= cnt_s1 - bfe_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load.load) begin
			buf_s1 <= load.bytes;
		end else if (take) begin
			buf_s1 <= buf_s1 >> 8;
		end
	end

	assign result.valid      = (cnt_s1 != '0);
	assign result.out_byte   = buf_s1[0];
	assign result.run_last   = (cnt_s1 == bfe_pkg::CNT_W'(1));
	assign result.frame_last = (cnt_s1 == bfe_pkg::CNT_W'(1)) && end_s1;

endmodule

// File: design/bfe_framer.sv
// ----------------------------------------------------------------------------
// bfe_framer
// Frame state and Fletcher-8 sums; forms the bytes that one request causes.
// ----------------------------------------------------------------------------
module bfe_framer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  bfe_pkg::item_t  item,
	output bfe_pkg::load_t  load
);

	bfe_pkg::byte_t sum_a_q;
	bfe_pkg::byte_t sum_b_q;
	bfe_pkg::byte_t left_q;
	logic           open_q;

	bfe_pkg::byte_t a2, a3, b2, b3, b4;
	bfe_pkg::byte_t pa, pb, left_dec;
	logic           is_start;
	logic           len_zero;
	logic           pay_end;

	// Header sums over class, id, length and the zero high byte, in closed form.
	assign a2 = item.msg_class + item.message_id;
	assign a3 = a2 + item.payload_length;
	assign b2 = item.msg_class + a2;
	assign b3 = b2 + a3;
	assign b4 = b3 + a3;

	assign pa       = sum_a_q + item.payload_byte;
	assign pb       = sum_b_q + pa;
	assign left_dec = left_q - 8'd1;

	assign is_start = (item.func == bfe_pkg::FUNC_START);
	assign len_zero = (item.payload_length == 8'd0);
	assign pay_end  = (left_dec == 8'd0);

	always_comb begin
		load       = '0;
		load.load  = is_start || open_q;
		if (is_start) begin
			load.bytes[0] = bfe_pkg::SYNC_FIRST;
			load.bytes[1] = bfe_pkg::SYNC_SECOND;
			load.bytes[2] = item.msg_class;
			load.bytes[3] = item.message_id;
			load.bytes[4] = item.payload_length;
			load.bytes[5] = bfe_pkg::LEN_HIGH;
			load.bytes[6] = a3;
			load.bytes[7] = b4;
			load.count    = len_zero ? bfe_pkg::CNT_W'(8) : bfe_pkg::CNT_W'(6);
			load.has_end  = len_zero;
		end else begin
			load.bytes[0] = item.payload_byte;
			load.bytes[1] = pa;
			load.bytes[2] = pb;
			load.count    = pay_end ? bfe_pkg::CNT_W'(3) : bfe_pkg::CNT_W'(1);
			load.has_end  = pay_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
			left_q  <= '0;
			open_q  <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				sum_a_q <= a3;
				sum_b_q <= b4;
				left_q  <= item.payload_length;
				open_q  <= !len_zero;
			end else if (open_q) begin
				sum_a_q <= pa;
				sum_b_q <= pb;
				left_q  <= left_dec;
				open_q  <= !pay_end;
			end
		end
	end

endmodule

// File: design/bfe_checker.sv
// ----------------------------------------------------------------------------
// bfe_checker
// Port-level checks on the frame encoder, bound to its top level.
// ----------------------------------------------------------------------------
module bfe_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_ready,
	input logic           item_func,
	input logic           result_valid,
	input logic           result_ready,
	input bfe_pkg::byte_t out_byte,
	input logic           run_last,
	input logic           frame_last
);

	// A stalled result keeps its byte and flags.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
		result_valid && $stable(out_byte) && $stable(run_last) && $stable(frame_last))
		else $error("stalled result changed");

	// The end of a frame is always the last byte of its request.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_last |-> run_last)
		else $error("frame end not on last byte of request");

	// A start request is answered at once by the first sync byte.
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_func == bfe_pkg::FUNC_START) |=>
		result_valid && (out_byte == bfe_pkg::SYNC_FIRST) && !run_last)
		else $error("start request did not open with sync byte");

	// No new request is taken while bytes of the previous one remain behind.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !run_last |-> !item_ready)
		else $error("request taken in the middle of a byte run");

endmodule

bind binary_frame_encoder bfe_checker u_bfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_func    (item.func),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.out_byte     (result.out_byte),
	.run_last     (result.run_last),
	.frame_last   (result.frame_last)
);
